@@ sv/bfa_pkg.sv @@
// ----------------------------------------------------------------------------
// bfa_pkg: shared definitions for the bitmap first-free allocator
// Holds the operation and status codes, field widths, reset values and the
// result type of the byte search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

	// Width of the slot index fields and reach of an index.
	localparam int IDX_W = 8;
	localparam int IDX_REACH = 256;

	// Width of the slot count register and of the active limit.
	localparam int LIM_W = 9;
	localparam logic [LIM_W-1:0] SLOTS_RESET = 9'd256;

	// Default number of slots in the bitmap.
	localparam int DEFAULT_NUM_SLOTS = 256;

	// Request operation codes.
	typedef enum logic [2:0] {
		OP_ALLOC = 3'd0,
		OP_FREE  = 3'd1,
		OP_SET   = 3'd2,
		OP_CLEAR = 3'd3,
		OP_GET   = 3'd4
	} op_t;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NONE  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// Outcome of searching one bitmap byte for its lowest free slot.
	typedef struct packed {
		logic       found;
		logic [2:0] pos;
		logic       last;
	} search_t;

endpackage

`default_nettype wire

@@ sv/bfa_byte_search.sv @@
// ----------------------------------------------------------------------------
// bfa_byte_search: lowest free slot in one bitmap byte
// Masks off the slots of the byte at or above the active limit, finds the
// lowest clear bit among the rest and tells whether this is the last byte
// below the limit.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_byte_search #(
	parameter int BYTE_AW = 5
) (
	input  wire logic [7:0]                byte_data,
	input  wire logic [BYTE_AW-1:0]        byte_addr,
	input  wire logic [bfa_pkg::LIM_W-1:0] limit,
	output bfa_pkg::search_t               result
);

	localparam int LIM_W = bfa_pkg::LIM_W;

	logic [LIM_W-1:0] base;
	logic [LIM_W-1:0] remain;
	logic             in_range;
	logic [7:0]       cand;

	// First slot of this byte and the slots left below the limit.
	assign base     = LIM_W'({byte_addr, 3'b000});
	assign in_range = limit > base;
	assign remain   = limit - base;

	// Free slots of the byte that lie below the limit.
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			cand[i] = in_range && (remain > LIM_W'(i)) && !byte_data[i];
		end
	end

	// Priority encode the lowest candidate.
	always_comb begin
		result.pos = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (cand[i]) begin
				result.pos = 3'(i);
			end
		end
		result.found = |cand;
		result.last  = !in_range || (remain <= LIM_W'(8));
	end

endmodule

`default_nettype wire

@@ sv/bfa_bitmap.sv @@
// ----------------------------------------------------------------------------
// bfa_bitmap: slot bitmap storage
// One byte per eight slots, one read and one write port. Reset clears every
// byte so that all slots start out free.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_bitmap #(
	parameter int MAP_BYTES = 32,
	parameter int BYTE_AW   = 5
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [BYTE_AW-1:0] rd_addr,
	output logic      [7:0]         rd_data,
	input  wire logic               wr_en,
	input  wire logic [BYTE_AW-1:0] wr_addr,
	input  wire logic [7:0]         wr_data
);

	logic [7:0] map_q [MAP_BYTES];

	// Byte storage, cleared as a whole by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAP_BYTES; i++) begin
				map_q[i] <= 8'h00;
			end
		end else if (wr_en) begin
			map_q[wr_addr] <= wr_data;
		end
	end

	assign rd_data = map_q[rd_addr];

endmodule

`default_nettype wire

@@ sv/bitmap_first_free_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator: first-fit slot allocator over a bitmap
// Sequencer around the bitmap storage and a one-byte search unit.
// ----------------------------------------------------------------------------
// The block takes one request at a time and answers each with exactly one
// result. Free, set, clear and get touch a single bitmap byte: the request
// passes through the scan and response states, and the next request can be
// taken once the block is back in idle. Alloc walks the bitmap one byte per
// cycle from slot zero through the byte search unit. At least one byte is
// always scanned, and at most the active limit divided by eight and rounded
// up. Requests are stalled while one is in flight; a finished result waits in
// the output register until it is taken. The slot count register must be
// written only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_first_free_allocator #(
	parameter int NUM_SLOTS = bfa_pkg::DEFAULT_NUM_SLOTS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// Request channel.
	input  wire logic                      req_valid,
	output logic                           req_stall,
	input  wire logic [2:0]                op,
	input  wire logic [bfa_pkg::IDX_W-1:0] slot_index,
	// Result channel.
	output logic                           rsp_valid,
	input  wire logic                      rsp_stall,
	output logic      [1:0]                status,
	output logic      [bfa_pkg::IDX_W-1:0] granted_index,
	output logic                           bit_value,
	// Slot count register write.
	input  wire logic                      cfg_wr_en,
	input  wire logic [bfa_pkg::LIM_W-1:0] cfg_wr_data
);

	localparam int IDX_W       = bfa_pkg::IDX_W;
	localparam int LIM_W       = bfa_pkg::LIM_W;
	localparam int REACH_SLOTS = (NUM_SLOTS < bfa_pkg::IDX_REACH) ? NUM_SLOTS
	                                                              : bfa_pkg::IDX_REACH;
	localparam int MAP_BYTES   = (REACH_SLOTS + 7) / 8;
	localparam int BYTE_AW     = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam logic [LIM_W-1:0] REACH_LIM = LIM_W'(REACH_SLOTS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_RESP = 3'b100
	} state_t;

	state_t               state_q;
	logic [LIM_W-1:0]     slots_in_use_q;
	logic [BYTE_AW-1:0]   ptr_q;
	logic                 rsp_valid_q;

	logic [2:0]           op_q;
	logic [IDX_W-1:0]     idx_q;
	logic [LIM_W-1:0]     lim_q;
	logic                 range_ok_q;
	logic [1:0]           res_status_q;
	logic [IDX_W-1:0]     res_granted_q;
	logic                 res_bit_q;
	logic [1:0]           status_q;
	logic [IDX_W-1:0]     granted_q;
	logic                 bit_q;

	logic                 req_take;
	logic                 out_free;
	logic [LIM_W-1:0]     lim_now;
	logic                 idx_ok_now;
	logic [7:0]           rd_data;
	logic                 wr_en;
	logic [7:0]           wr_data;
	logic [7:0]           bit_mask;
	logic                 scan_done;
	logic [1:0]           nxt_status;
	logic [IDX_W-1:0]     nxt_granted;
	logic                 nxt_bit;
	bfa_pkg::search_t     search;

	// Handshakes.
	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// Active limit: the slot count clipped to the bitmap's reach.
	assign lim_now    = (slots_in_use_q > REACH_LIM) ? REACH_LIM : slots_in_use_q;
	assign idx_ok_now = LIM_W'(slot_index) < lim_now;

	// Bitmap storage, read at the scan pointer and written back there.
	bfa_bitmap #(
		.MAP_BYTES (MAP_BYTES),
		.BYTE_AW   (BYTE_AW)
	) u_bitmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (ptr_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (ptr_q),
		.wr_data (wr_data)
	);

	// Search unit for the byte under the pointer.
	bfa_byte_search #(
		.BYTE_AW (BYTE_AW)
	) u_search (
		.byte_data (rd_data),
		.byte_addr (ptr_q),
		.limit     (lim_q),
		.result    (search)
	);

	// Work of one scan cycle: the result, the bitmap update and completion.
	always_comb begin
		wr_en       = 1'b0;
		wr_data     = rd_data;
		scan_done   = 1'b1;
		nxt_status  = bfa_pkg::ST_OK;
		nxt_granted = '0;
		nxt_bit     = 1'b0;
		bit_mask    = 8'h01 << idx_q[2:0];
		if (state_q == ST_SCAN) begin
			unique case (op_q)
				bfa_pkg::OP_ALLOC: begin
					if (search.found) begin
						wr_en       = 1'b1;
						wr_data     = rd_data | (8'h01 << search.pos);
						nxt_granted = IDX_W'({ptr_q, search.pos});
					end else if (search.last) begin
						nxt_status = bfa_pkg::ST_NONE;
					end else begin
						scan_done = 1'b0;
					end
				end
				bfa_pkg::OP_FREE: begin
					if (!range_ok_q) begin
						nxt_status = bfa_pkg::ST_RANGE;
					end else if ((rd_data & bit_mask) != 8'h00) begin
						wr_en   = 1'b1;
						wr_data = rd_data & ~bit_mask;
					end else begin
						nxt_status = bfa_pkg::ST_NONE;
					end
				end
				bfa_pkg::OP_SET: begin
					if (!range_ok_q) begin
						nxt_status = bfa_pkg::ST_RANGE;
					end else begin
						wr_en   = 1'b1;
						wr_data = rd_data | bit_mask;
					end
				end
				bfa_pkg::OP_CLEAR: begin
					if (!range_ok_q) begin
						nxt_status = bfa_pkg::ST_RANGE;
					end else begin
						wr_en   = 1'b1;
						wr_data = rd_data & ~bit_mask;
					end
				end
				bfa_pkg::OP_GET: begin
					if (!range_ok_q) begin
						nxt_status = bfa_pkg::ST_RANGE;
					end else begin
						nxt_bit = (rd_data & bit_mask) != 8'h00;
					end
				end
				default: begin
					// Unused codes leave the bitmap alone and report ok.
					nxt_status = bfa_pkg::ST_OK;
				end
			endcase
		end
	end

	// Sequencer, scan pointer, slot count register and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			ptr_q          <= '0;
			slots_in_use_q <= bfa_pkg::SLOTS_RESET;
			rsp_valid_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				slots_in_use_q <= cfg_wr_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						state_q <= ST_SCAN;
						if (op == bfa_pkg::OP_ALLOC || !idx_ok_now) begin
							ptr_q <= '0;
						end else begin
							ptr_q <= slot_index[BYTE_AW+2:3];
						end
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_RESP;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (state_q == ST_RESP && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request fields, pending result and output payload.
	always_ff @(posedge clk) begin
		if (req_take) begin
			op_q       <= op;
			idx_q      <= slot_index;
			lim_q      <= lim_now;
			range_ok_q <= idx_ok_now;
		end
		if (state_q == ST_SCAN && scan_done) begin
			res_status_q  <= nxt_status;
			res_granted_q <= nxt_granted;
			res_bit_q     <= nxt_bit;
		end
		if (state_q == ST_RESP && out_free) begin
			status_q  <= res_status_q;
			granted_q <= res_granted_q;
			bit_q     <= res_bit_q;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign granted_index = granted_q;
	assign bit_value     = bit_q;

	// The bitmap is only written during a scan cycle.
	a_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_SCAN))
		else $error("bitmap written outside a scan cycle");

	// The scan pointer never leaves the bitmap while scanning.
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (int'(ptr_q) < MAP_BYTES))
		else $error("scan pointer beyond the bitmap");

	// A granted slot lies below the limit in force for the request.
	a_grant_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP && op_q == bfa_pkg::OP_ALLOC
		 && res_status_q == bfa_pkg::ST_OK) |-> (LIM_W'(res_granted_q) < lim_q))
		else $error("granted slot at or above the active limit");

	// A taken request always starts a scan cycle.
	a_take_to_scan: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> (state_q == ST_SCAN))
		else $error("request taken without a scan");

	// A new result is loaded only when the output register is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |=> rsp_valid_q && $stable(status_q)
		&& $stable(granted_q) && $stable(bit_q))
		else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: request and result checks for the bitmap first-free allocator
// Sends directed and random alloc, free, set, clear and get requests under
// several slot counts. A small checker class tracks its own copy of the
// bitmap, predicts every result and compares each one as it arrives.
// Random idle gaps and stalls run on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Field widths taken from the shared package.
	localparam int IDX_W = bfa_pkg::IDX_W;
	localparam int LIM_W = bfa_pkg::LIM_W;

	// Opcodes outside the defined set, which the block ignores.
	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	// Cycles to let pass before a slot count write; covers a full alloc scan.
	localparam int SETTLE_CYCLES = 40;
	// Length of the long result hold-off.
	localparam int LONG_HOLD_CYCLES = 300;
	// Bound on the final drain, in cycles.
	localparam int DRAIN_LIMIT = 5000;

	// One predicted result.
	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] granted;
		logic             bit_val;
	} alloc_result_t;

	// Tracks the bitmap, predicts each result and checks the arriving ones.
	class alloc_checker;
		bit [7:0]          slot_map [0:31];
		bit [LIM_W-1:0]    slot_count;
		alloc_result_t     awaited_results [$];
		int                errors;
		int                requests_noted;
		int                results_checked;

		function new();
			foreach (slot_map[i]) slot_map[i] = '0;
			slot_count = bfa_pkg::SLOTS_RESET;
			errors = 0;
			requests_noted = 0;
			results_checked = 0;
		endfunction

		function void set_slot_count(bit [LIM_W-1:0] value);
			slot_count = value;
		endfunction

		// The count is clamped to the bitmap size and to the reach of an index.
		function int unsigned active_limit();
			int unsigned lim;
			lim = slot_count;
			if (lim > bfa_pkg::DEFAULT_NUM_SLOTS) lim = bfa_pkg::DEFAULT_NUM_SLOTS;
			if (lim > bfa_pkg::IDX_REACH) lim = bfa_pkg::IDX_REACH;
			return lim;
		endfunction

		function bit slot_taken(int unsigned pos);
			return slot_map[pos / 8][pos % 8];
		endfunction

		function void mark_slot(int unsigned pos, bit taken);
			slot_map[pos / 8][pos % 8] = taken;
		endfunction

		function int outstanding();
			return awaited_results.size();
		endfunction

		// Works out the result of an accepted request and queues it.
		function void note_request(logic [2:0] op_code, logic [IDX_W-1:0] idx);
			alloc_result_t res;
			int unsigned lim;
			int unsigned pos;
			bit found;
			res = '0;
			lim = active_limit();
			found = 1'b0;
			case (op_code)
				bfa_pkg::OP_ALLOC: begin
					res.status = bfa_pkg::ST_NONE;
					for (pos = 0; pos < lim && !found; pos++) begin
						if (!slot_taken(pos)) begin
							mark_slot(pos, 1'b1);
							res.status = bfa_pkg::ST_OK;
							res.granted = pos[IDX_W-1:0];
							found = 1'b1;
						end
					end
				end
				bfa_pkg::OP_FREE, bfa_pkg::OP_SET, bfa_pkg::OP_CLEAR, bfa_pkg::OP_GET: begin
					if (idx >= lim) begin
						res.status = bfa_pkg::ST_RANGE;
					end else if (op_code == bfa_pkg::OP_FREE) begin
						if (slot_taken(idx)) mark_slot(idx, 1'b0);
						else res.status = bfa_pkg::ST_NONE;
					end else if (op_code == bfa_pkg::OP_SET) begin
						mark_slot(idx, 1'b1);
					end else if (op_code == bfa_pkg::OP_CLEAR) begin
						mark_slot(idx, 1'b0);
					end else begin
						res.bit_val = slot_taken(idx);
					end
				end
				default: begin
				end
			endcase
			awaited_results.push_back(res);
			requests_noted++;
		endfunction

		function void report(string field, int exp_val, int act_val);
			errors++;
			$display("%0d ns: %s mismatch, expected %0d, actual %0d",
				$time, field, exp_val, act_val);
		endfunction

		// Compares one accepted result with the oldest prediction.
		function void check_result(logic [1:0] st, logic [IDX_W-1:0] granted, logic bit_val);
			alloc_result_t exp_res;
			results_checked++;
			if (awaited_results.size() == 0) begin
				errors++;
				$display("%0d ns: result with no request waiting, status %0d index %0d",
					$time, st, granted);
			end else begin
				exp_res = awaited_results.pop_front();
				if (st !== exp_res.status) report("status", exp_res.status, st);
				if (granted !== exp_res.granted) report("granted_index", exp_res.granted, granted);
				if (bit_val !== exp_res.bit_val) report("bit_value", exp_res.bit_val, bit_val);
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             req_valid;
	logic             req_stall;
	logic [2:0]       op;
	logic [IDX_W-1:0] slot_index;
	logic             rsp_valid;
	logic             rsp_stall;
	logic [1:0]       status;
	logic [IDX_W-1:0] granted_index;
	logic             bit_value;
	logic             cfg_wr_en;
	logic [LIM_W-1:0] cfg_wr_data;

	alloc_checker scoreboard = new();

	// Shared controls from the stimulus to the result side, and a phase counter.
	bit quiet_mode = 1'b0;
	bit hold_request = 1'b0;
	int phases_run = 0;

	bitmap_first_free_allocator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.op           (op),
		.slot_index   (slot_index),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.status       (status),
		.granted_index(granted_index),
		.bit_value    (bit_value),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	// Clock generation.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog against a hung run.
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Result side: random stalls per result, plus one long hold-off on request.
	initial begin : result_side
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
				scoreboard.check_result(status, granted_index, bit_value);
				stall_left = quiet_mode ? 0 : $urandom_range(0, 6);
			end
			if (hold_request) begin
				hold_left = LONG_HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// Offers one request after a random gap and waits until it is taken.
	task automatic send_request(logic [2:0] op_code, logic [IDX_W-1:0] idx);
		int gap;
		gap = quiet_mode ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		op <= op_code;
		slot_index <= idx;
		@(posedge clk);
		while (req_stall !== 1'b0) @(posedge clk);
		scoreboard.note_request(op_code, idx);
	endtask

	// Stops offering requests and waits for every predicted result.
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (scoreboard.outstanding() > 0) @(posedge clk);
	endtask

	// Writes the slot count once the block has gone idle.
	task automatic write_slot_count(logic [LIM_W-1:0] value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		scoreboard.set_slot_count(value);
	endtask

	// Random opcode, with alloc taking the given share.
	function automatic logic [2:0] pick_op(int unsigned alloc_pct);
		int unsigned r;
		if ($urandom_range(0, 99) < alloc_pct) return bfa_pkg::OP_ALLOC;
		r = $urandom_range(0, 99);
		if (r < 35) return bfa_pkg::OP_FREE;
		if (r < 50) return bfa_pkg::OP_SET;
		if (r < 65) return bfa_pkg::OP_CLEAR;
		if (r < 95) return bfa_pkg::OP_GET;
		return 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
	endfunction

	// Random index, mostly inside the active limit.
	function automatic logic [IDX_W-1:0] pick_index(int unsigned lim);
		if (lim > 0 && $urandom_range(0, 3) != 0)
			return IDX_W'($urandom_range(0, lim - 1));
		return IDX_W'($urandom_range(0, bfa_pkg::IDX_REACH - 1));
	endfunction

	// Main stimulus.
	initial begin : stimulus
		int unsigned phase_counts [12] = '{256, 8, 64, 13, 0, 511, 128, 256, 40, 300, 8, 256};
		int unsigned phase_items [12] = '{150, 80, 100, 80, 40, 120, 120, 250, 100, 100, 60, 50};
		int unsigned phase_alloc [12] = '{70, 50, 40, 60, 50, 30, 70, 80, 30, 50, 60, 20};
		int drain_cycles;

		arst_n <= 1'b0;
		req_valid <= 1'b0;
		op <= bfa_pkg::OP_ALLOC;
		slot_index <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: full bitmap from reset, edges of the index range.
		send_request(bfa_pkg::OP_ALLOC, 8'd0);
		send_request(bfa_pkg::OP_ALLOC, 8'd255);
		send_request(bfa_pkg::OP_GET, 8'd0);
		send_request(bfa_pkg::OP_GET, 8'd255);
		send_request(bfa_pkg::OP_SET, 8'd255);
		send_request(bfa_pkg::OP_GET, 8'd255);
		send_request(bfa_pkg::OP_FREE, 8'd255);
		send_request(bfa_pkg::OP_FREE, 8'd255);
		send_request(bfa_pkg::OP_CLEAR, 8'd1);
		send_request(bfa_pkg::OP_SET, 8'd7);
		send_request(bfa_pkg::OP_ALLOC, 8'd0);
		send_request(OP_UNUSED_LO, 8'd255);
		send_request(OP_UNUSED_HI, 8'd0);
		send_request(bfa_pkg::OP_FREE, 8'd0);

		// Directed: eight slots, filled until none is free, then out of range.
		write_slot_count(9'd8);
		repeat (7) send_request(bfa_pkg::OP_ALLOC, 8'd0);
		send_request(bfa_pkg::OP_GET, 8'd8);
		send_request(bfa_pkg::OP_FREE, 8'd255);
		send_request(bfa_pkg::OP_SET, 8'd200);

		// Directed: a count of zero leaves nothing in range.
		write_slot_count(9'd0);
		send_request(bfa_pkg::OP_ALLOC, 8'd0);
		send_request(bfa_pkg::OP_GET, 8'd0);

		// Directed: a count that is not a multiple of eight.
		write_slot_count(9'd13);
		send_request(bfa_pkg::OP_SET, 8'd12);
		send_request(bfa_pkg::OP_GET, 8'd13);

		// Random phases over a range of slot counts.
		for (int p = 0; p < 12; p++) begin
			write_slot_count(phase_counts[p][LIM_W-1:0]);
			quiet_mode = (p == 4);
			phases_run++;
			for (int n = 0; n < phase_items[p]; n++) begin
				if (p == 2 && n == 20) hold_request = 1'b1;
				if (p == 6 && n == 50) wait_drained();
				send_request(pick_op(phase_alloc[p]), pick_index(scoreboard.active_limit()));
			end
		end
		quiet_mode = 1'b0;

		// Drain, with a bound, then let the block settle.
		req_valid <= 1'b0;
		drain_cycles = 0;
		while (scoreboard.outstanding() > 0 && drain_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (scoreboard.outstanding() != 0) begin
			scoreboard.errors++;
			$display("%0d ns: %0d results never arrived", $time, scoreboard.outstanding());
		end

		$display("Ran %0d requests and checked %0d results over %0d slot count settings,",
			scoreboard.requests_noted, scoreboard.results_checked, phases_run + 4);
		$display("including zero, odd, oversized and full counts, with %0d errors.",
			scoreboard.errors);
		if (scoreboard.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
sv/bfa_pkg.sv
sv/bfa_byte_search.sv
sv/bfa_bitmap.sv
sv/bitmap_first_free_allocator.sv
sim/testbench.sv
